>>> design/dpht_pkg.sv
`default_nettype none
package dpht_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int USED_W     = 7;
  localparam int LOAD_LIMIT = (SLOTS * 3) / 4;

  localparam int PAGE_W     = 32;
  localparam int FP_W       = 33;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 64;
  localparam int REG_IDX_W  = ADDR_W - 3;

  localparam logic [REG_IDX_W-1:0] REG_FILE_PAGES = '0;

  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FLUSH  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLOSED = 3'd6;

  typedef enum logic [2:0] {
    RES_HIT,
    RES_DECIDE,
    RES_FLUSH,
    RES_EMPTY,
    RES_CLOSED
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     home_sel;
    logic     step;
    logic     mark_empty;
    logic     load_out;
    res_sel_t res_sel;
    logic     clear;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic cnt_done;
    logic page_match;
    logic any_valid;
    logic last_valid;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> design/dpht_ctrl.sv
`default_nettype none
module dpht_ctrl
  import dpht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [KIND_W-1:0] in_kind,
  output logic                   in_ready,
  input  wire dp_sts_t           sts,
  output dp_cmd_t                cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_EMIT,
    S_SCAN,
    S_CEMIT
  } state_t;

  state_t   state_r, state_nxt;
  res_sel_t sel_r, sel_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.res_sel = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in  = 1'b1;
          cmd.home_sel = (in_kind == KIND_MODIFY);
          case (in_kind)
            KIND_MODIFY: state_nxt = S_PROBE;
            KIND_COMMIT: begin
              if (sts.any_valid) begin
                state_nxt = S_SCAN;
              end else begin
                sel_nxt   = RES_EMPTY;
                state_nxt = S_EMIT;
              end
            end
            KIND_CLOSE: begin
              sel_nxt   = RES_CLOSED;
              state_nxt = S_EMIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PROBE: begin
        // slot data for idx is read this cycle, compared in S_CMP
        if (sts.cnt_done) begin
          sel_nxt   = RES_DECIDE;
          state_nxt = S_EMIT;
        end else if (!sts.cur_valid) begin
          cmd.mark_empty = 1'b1;
          sel_nxt        = RES_DECIDE;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.page_match) begin
          sel_nxt   = RES_HIT;
          state_nxt = S_EMIT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.clear    = (sel_r == RES_EMPTY) || (sel_r == RES_CLOSED);
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.cur_valid) begin
          state_nxt = S_CEMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_CEMIT: begin
        cmd.res_sel = RES_FLUSH;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.last_valid) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= RES_HIT;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/dpht_dp.sv
`default_nettype none
module dpht_dp
  import dpht_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [PAGE_W-1:0]     in_page_number,
  input  wire logic [FP_W-1:0]       file_pages,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [PAGE_W-1:0]          out_page_out,
  output logic [SLOT_OUT_W-1:0]      out_slot,
  output logic                       out_last
);

  logic [SLOTS-1:0]    valid_r;
  logic [PAGE_W-1:0]   page_mem [SLOTS];
  logic [PAGE_W-1:0]   rd_data_r;
  logic [PAGE_W-1:0]   page_r;
  logic [SLOT_W-1:0]   idx_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                empty_found_r;
  logic [SLOT_W-1:0]   empty_idx_r;
  logic [USED_W-1:0]   used_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [PAGE_W-1:0]   out_page_r, out_page_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_range;
  logic                room;
  logic                dec_new;
  logic                wr_new;

  assign in_range = ({1'b0, page_r} < file_pages);
  assign room     = (({1'b0, used_r} + 8'd1) < 8'(LOAD_LIMIT));
  assign dec_new  = in_range && empty_found_r && room;
  assign wr_new   = cmd.load_out && (cmd.res_sel == RES_DECIDE) && dec_new;

  assign sts.cur_valid  = valid_r[idx_r];
  assign sts.cnt_done   = (cnt_r == CNT_W'(SLOTS));
  assign sts.page_match = (rd_data_r == page_r);
  assign sts.any_valid  = |valid_r;
  // nothing valid above the current slot
  assign sts.last_valid = ((valid_r >> idx_r) >> 1) == '0;
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    out_status_nxt = ST_HIT;
    out_page_nxt   = page_r;
    out_slot_nxt   = SLOT_OUT_W'(idx_r);
    out_last_nxt   = 1'b1;
    case (cmd.res_sel)
      RES_HIT: begin
        out_status_nxt = ST_HIT;
      end
      RES_DECIDE: begin
        if (!in_range) begin
          out_status_nxt = ST_RANGE;
          out_slot_nxt   = '0;
        end else if (dec_new) begin
          out_status_nxt = ST_NEW;
          out_slot_nxt   = SLOT_OUT_W'(empty_idx_r);
        end else begin
          out_status_nxt = ST_FULL;
          out_slot_nxt   = '0;
        end
      end
      RES_FLUSH: begin
        out_status_nxt = ST_FLUSH;
        out_page_nxt   = rd_data_r;
        out_last_nxt   = sts.last_valid;
      end
      RES_EMPTY: begin
        out_status_nxt = ST_EMPTY;
        out_page_nxt   = '0;
        out_slot_nxt   = '0;
      end
      RES_CLOSED: begin
        out_status_nxt = ST_CLOSED;
        out_page_nxt   = '0;
        out_slot_nxt   = '0;
      end
      default: begin
        out_status_nxt = ST_HIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_new) begin
      page_mem[empty_idx_r] <= page_r;
    end
    rd_data_r <= page_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        valid_r <= '0;
        used_r  <= '0;
      end else if (wr_new) begin
        valid_r[empty_idx_r] <= 1'b1;
        used_r               <= used_r + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      page_r        <= in_page_number;
      idx_r         <= cmd.home_sel ? in_page_number[SLOT_W-1:0] : '0;
      cnt_r         <= '0;
      empty_found_r <= 1'b0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mark_empty) begin
      empty_found_r <= 1'b1;
      empty_idx_r   <= idx_r;
    end
    if (cmd.load_out) begin
      out_status_r <= out_status_nxt;
      out_page_r   <= out_page_nxt;
      out_slot_r   <= out_slot_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_page_out = out_page_r;
  assign out_slot     = out_slot_r;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire

>>> design/dirty_page_hash_table.sv
// Channel   Handshake          Payload
// in        in_valid/in_ready  in_kind, in_page_number
// out       out_valid/out_ready out_status, out_page_out, out_slot, out_last
// config    psel/penable/pready paddr, pwrite, pwdata, prdata (file_pages at 0x0)
//
// Modify: each occupied slot probed takes a slot RAM read, then a compare; the empty slot
// ends a miss. Commit: scans the slots up to the highest held one and sends one result per
// flushed page; an empty commit and a close send a single result.
// Reset clears the slot valid flops at once; no clearing pass of the page RAM.
// One item in flight; a stalled out channel holds the controller in its emit state.
`default_nettype none
module dirty_page_hash_table
  import dpht_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic [PAGE_W-1:0]     in_page_number,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [PAGE_W-1:0]          out_page_out,
  output logic [SLOT_OUT_W-1:0]      out_slot,
  output logic                       out_last,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [FP_W-1:0] file_pages_r;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:3] == REG_FILE_PAGES);
  assign prdata  = reg_sel ? DATA_W'(file_pages_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_pages_r <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      file_pages_r <= pwdata[FP_W-1:0];
    end
  end

  dpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpht_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_page_number (in_page_number),
    .file_pages     (file_pages_r),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_page_out   (out_page_out),
    .out_slot       (out_slot),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  a_new_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NEW) |-> ({1'b0, out_page_out} < file_pages_r))
    else $error("new entry for a page beyond the file");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_MODIFY || in_kind == KIND_COMMIT ||
     in_kind == KIND_CLOSE)) |=> !in_ready)
    else $error("controller took a transfer but stayed idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten while held");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_FLUSH) |-> out_last)
    else $error("single result without last");
`endif

endmodule
`default_nettype wire

>>> tb/sv/dirty_page_hash_table_tb.sv
module dirty_page_hash_table_tb;
  import dpht_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS = 73;
  localparam int MAX_PRINTS = 60;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page;
  } page_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [PAGE_W-1:0]     page;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  last;
  } page_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [PAGE_W-1:0] out_page_out;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // shadow of the dirty page table
  bit tbl_valid [SLOTS];
  logic [PAGE_W-1:0] tbl_page [SLOTS];
  int unsigned tbl_count;
  logic [FP_W-1:0] file_pages_q;

  page_req_t pend_q[$];
  page_result_t expected_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 13;
  int unsigned recv_stall_pct = 72;

  dirty_page_hash_table i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_page_number(in_page_number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_page_out(out_page_out),
    .out_slot(out_slot),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_cnt < MAX_PRINTS)
      $display("MISMATCH @%0t %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic void push_result(logic [STATUS_W-1:0] status, logic [PAGE_W-1:0] page,
                                      logic [SLOT_OUT_W-1:0] slot, logic last);
    page_result_t res;
    res.status = status;
    res.page = page;
    res.slot = slot;
    res.last = last;
    expected_q.push_back(res);
  endfunction

  function automatic void clear_table();
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    tbl_count = 0;
  endfunction

  // Works out the results of one accepted request and updates the shadow table.
  function automatic void apply_request(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] page);
    logic [SLOT_W-1:0] home;
    logic [SLOT_W-1:0] idx;
    int hit_slot;
    int free_slot;
    int total;
    int n;
    home = page[SLOT_W-1:0];
    hit_slot = -1;
    free_slot = -1;
    total = 0;
    n = 0;
    case (kind)
      KIND_MODIFY: begin
        for (int i = 0; i < SLOTS; i++) begin
          idx = home + SLOT_W'(i);
          if (!tbl_valid[idx]) break;
          if (tbl_page[idx] == page) begin
            hit_slot = idx;
            break;
          end
        end
        if (hit_slot >= 0) begin
          push_result(ST_HIT, page, SLOT_OUT_W'(hit_slot), 1'b1);
        end else if ({1'b0, page} >= file_pages_q) begin
          push_result(ST_RANGE, page, '0, 1'b1);
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            idx = home + SLOT_W'(i);
            if (!tbl_valid[idx]) begin
              free_slot = idx;
              break;
            end
          end
          if (free_slot >= 0 && tbl_count + 1 < LOAD_LIMIT) begin
            tbl_valid[free_slot] = 1'b1;
            tbl_page[free_slot] = page;
            tbl_count++;
            push_result(ST_NEW, page, SLOT_OUT_W'(free_slot), 1'b1);
          end else begin
            push_result(ST_FULL, page, '0, 1'b1);
          end
        end
      end
      KIND_COMMIT: begin
        foreach (tbl_valid[i]) if (tbl_valid[i]) total++;
        if (total > LOAD_LIMIT) total = LOAD_LIMIT;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && n < total) begin
            push_result(ST_FLUSH, tbl_page[i], SLOT_OUT_W'(i), n == total - 1);
            n++;
          end
        end
        if (total == 0) push_result(ST_EMPTY, '0, '0, 1'b1);
        clear_table();
      end
      KIND_CLOSE: begin
        clear_table();
        push_result(ST_CLOSED, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Mostly in-range pages, some at the file_pages boundary, some anywhere.
  function automatic logic [PAGE_W-1:0] pick_page();
    int unsigned r;
    logic [FP_W-1:0] edge_pg;
    r = $urandom_range(99);
    if (file_pages_q == 0 || r < 10) return $urandom;
    if (r < 20) begin
      edge_pg = file_pages_q + FP_W'($urandom_range(2)) - 1;
      return edge_pg[PAGE_W-1:0];
    end
    if (file_pages_q > {1'b0, {PAGE_W{1'b1}}}) return $urandom;
    return $urandom_range(file_pages_q[PAGE_W-1:0] - 1, 0);
  endfunction

  function automatic void queue_req(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] page);
    page_req_t req;
    req.kind = kind;
    req.page = page;
    pend_q.push_back(req);
  endfunction

  // input driver; the shadow table advances on each accepted transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_request(in_kind, in_page_number);
      if (!in_valid || in_ready) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_kind <= pend_q[0].kind;
          in_page_number <= pend_q[0].page;
          pend_q.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    page_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected, status", out_status, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_page_out !== want.page) report_mismatch("page_out", out_page_out, want.page);
          if (out_slot !== want.slot) report_mismatch("slot", out_slot, want.slot);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pend_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write file_pages once the table is idle, then read it back
  task automatic set_file_pages(logic [FP_W-1:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_FILE_PAGES, 3'b000};
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    file_pages_q = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[FP_W-1:0] !== value) report_mismatch("file_pages readback", prdata, value);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [FP_W-1:0] phase_pages [6];
    logic [PAGE_W-1:0] pool [$];
    logic [PAGE_W-1:0] pg;
    int unsigned r;
    int txn_len;
    int produced;
    phase_pages[0] = 33'h1_0000_0000;
    phase_pages[1] = 33'd200;
    phase_pages[2] = {1'b0, $urandom};
    phase_pages[3] = 33'd0;
    phase_pages[4] = 33'd1000;
    phase_pages[5] = 33'h1_0000_0000;
    file_pages_q = '0;
    clear_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // file_pages is zero after reset: every modify is out of range
    queue_req(KIND_MODIFY, 32'h0000_0000);
    queue_req(KIND_MODIFY, 32'hFFFF_FFFF);
    queue_req(KIND_COMMIT, 32'h0000_0000);
    queue_req(KIND_CLOSE, 32'hFFFF_FFFF);
    queue_req(KIND_UNDEF, 32'h1234_5678);
    set_file_pages(33'h1_0000_0000);
    // home slot collisions, wrap past the top slot, hit after probing
    queue_req(KIND_MODIFY, 32'd0);
    queue_req(KIND_MODIFY, 32'd0);
    queue_req(KIND_MODIFY, 32'd64);
    queue_req(KIND_MODIFY, 32'd128);
    queue_req(KIND_MODIFY, 32'd1);
    queue_req(KIND_MODIFY, 32'hFFFF_FFFF);
    queue_req(KIND_MODIFY, 32'd63);
    queue_req(KIND_MODIFY, 32'd128);
    queue_req(KIND_UNDEF, 32'hFFFF_FFFF);
    queue_req(KIND_COMMIT, 32'hFFFF_FFFF);
    queue_req(KIND_CLOSE, 32'd0);
    set_file_pages(33'd5);
    queue_req(KIND_MODIFY, 32'd4);
    queue_req(KIND_MODIFY, 32'd5);
    queue_req(KIND_MODIFY, 32'd6);
    queue_req(KIND_MODIFY, 32'hFFFF_FFFF);
    queue_req(KIND_CLOSE, 32'd0);

    for (int ph = 0; ph < 6; ph++) begin
      set_file_pages(phase_pages[ph]);
      if (ph < 2) begin
        send_idle_pct = 13;
        recv_stall_pct = 72;
      end else if (ph < 4) begin
        send_idle_pct = 72;
        recv_stall_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      produced = 0;
      while (produced < PHASE_ITEMS) begin
        // long transactions push the table into the full state
        txn_len = ($urandom_range(3) == 0) ? $urandom_range(75, 50) : $urandom_range(12, 1);
        if (txn_len > PHASE_ITEMS - produced) txn_len = PHASE_ITEMS - produced;
        pool.delete();
        repeat (txn_len) begin
          r = $urandom_range(99);
          if (r < 4) begin
            queue_req(KIND_UNDEF, $urandom);
          end else begin
            if (r < 30 && pool.size() != 0) begin
              pg = pool[$urandom_range(pool.size() - 1)];
            end else begin
              pg = pick_page();
              pool.push_back(pg);
            end
            queue_req(KIND_MODIFY, pg);
          end
          produced++;
        end
        // some transactions are left open and carry into the next one
        r = $urandom_range(99);
        if (r < 70) begin
          queue_req(KIND_COMMIT, $urandom);
          produced++;
        end else if (r < 90) begin
          queue_req(KIND_CLOSE, $urandom);
          produced++;
        end
      end
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/dpht_pkg.sv
design/dpht_ctrl.sv
design/dpht_dp.sv
design/dirty_page_hash_table.sv
tb/sv/dirty_page_hash_table_tb.sv
